// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, skipped while reset is asserted
`define CHECK_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that holds in reset as well
`define CHECK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== design/lz4bs_pkg.sv =====
package lz4bs_pkg;

    // block limits
    localparam int PAGE_BYTES    = 4096;
    localparam int MAX_SEQUENCES = 1024;
    localparam int MATCH_MAX     = 65535;
    localparam int MATCH_SAT     = 65536;

    localparam int LEN_W  = 13;
    localparam int SEQ_W  = 11;
    localparam int MACC_W = 17;

    localparam logic [7:0] EXT_CONTINUE = 8'hFF;
    localparam logic [3:0] NIBBLE_EXT   = 4'hF;
    localparam logic [3:0] MIN_MATCH    = 4'd4;

    typedef enum logic [1:0] {
        KIND_LITERAL  = 2'd0,
        KIND_SEQUENCE = 2'd1,
        KIND_FINISHED = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_LIT_OVER  = 3'd2,
        ERR_SEQ_OVER  = 3'd3,
        ERR_MATCH_LEN = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        PH_TOKEN     = 3'd0,
        PH_LIT_EXT   = 3'd1,
        PH_LITERALS  = 3'd2,
        PH_OFF_LO    = 3'd3,
        PH_OFF_HI    = 3'd4,
        PH_MATCH_EXT = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } in_t;

    typedef struct packed {
        kind_t              record_kind;
        logic [7:0]         literal_byte;
        logic [LEN_W-1:0]   literal_length;
        logic [15:0]        match_length;
        logic [15:0]        match_offset;
        logic [SEQ_W-1:0]   sequence_total;
        logic [LEN_W-1:0]   literal_total;
        err_t               error_code;
        logic               last_of_run;
    } out_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0]       count;
        out_t [0:2]       recs;
    } bundle_t;

    function automatic out_t rec_literal(input logic [7:0] b);
        out_t r;
        r = '0;
        r.record_kind  = KIND_LITERAL;
        r.literal_byte = b;
        return r;
    endfunction

    function automatic out_t rec_sequence(input logic [LEN_W-1:0] ll,
                                          input logic [15:0] ml,
                                          input logic [15:0] off);
        out_t r;
        r = '0;
        r.record_kind    = KIND_SEQUENCE;
        r.literal_length = ll;
        r.match_length   = ml;
        r.match_offset   = off;
        return r;
    endfunction

    function automatic out_t rec_finished(input logic [SEQ_W-1:0] st,
                                          input logic [LEN_W-1:0] lt);
        out_t r;
        r = '0;
        r.record_kind    = KIND_FINISHED;
        r.sequence_total = st;
        r.literal_total  = lt;
        return r;
    endfunction

    function automatic out_t rec_error(input err_t code);
        out_t r;
        r = '0;
        r.record_kind = KIND_ERROR;
        r.error_code  = code;
        return r;
    endfunction

endpackage

// ===== design/lz4bs_parser.sv =====
module lz4bs_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lz4bs_pkg::in_t      item,
    output lz4bs_pkg::bundle_t  bundle
);

    lz4bs_pkg::phase_t                 phase_reg, phase_next;
    logic [3:0]                        nibble_reg, nibble_next;
    logic [lz4bs_pkg::LEN_W-1:0]       lit_acc_reg, lit_acc_next;
    logic [lz4bs_pkg::LEN_W-1:0]       lit_rem_reg, lit_rem_next;
    logic [7:0]                        off_lo_reg, off_lo_next;
    logic [15:0]                       offset_reg, offset_next;
    logic [lz4bs_pkg::MACC_W-1:0]      ml_acc_reg, ml_acc_next;
    logic [lz4bs_pkg::LEN_W-1:0]       lit_cnt_reg, lit_cnt_next;
    logic [lz4bs_pkg::SEQ_W-1:0]       seq_cnt_reg, seq_cnt_next;
    logic                              drain_reg, drain_next;

    logic [lz4bs_pkg::LEN_W:0]         lit_sum;
    logic [lz4bs_pkg::LEN_W:0]         page_sum;
    logic [lz4bs_pkg::MACC_W:0]        ml_sum;
    logic                              do_lit_done;
    logic                              do_match_done;
    logic                              emit_lit;
    logic                              emit_seq;
    logic                              emit_fin;
    logic                              clear_all;
    lz4bs_pkg::err_t                   fail_code;
    logic [lz4bs_pkg::LEN_W-1:0]       seq_ll;
    logic [15:0]                       seq_ml;
    logic [15:0]                       seq_off;
    logic [lz4bs_pkg::SEQ_W-1:0]       fin_seq;
    logic [lz4bs_pkg::LEN_W-1:0]       fin_lit;
    logic [1:0]                        k;
    logic [7:0]                        b;
    logic                              last;

    assign b    = item.data_byte;
    assign last = item.end_of_block;

    // next state and record decisions
    always_comb
    begin
        phase_next    = phase_reg;
        nibble_next   = nibble_reg;
        lit_acc_next  = lit_acc_reg;
        lit_rem_next  = lit_rem_reg;
        off_lo_next   = off_lo_reg;
        offset_next   = offset_reg;
        ml_acc_next   = ml_acc_reg;
        lit_cnt_next  = lit_cnt_reg;
        seq_cnt_next  = seq_cnt_reg;
        drain_next    = drain_reg;
        lit_sum       = '0;
        page_sum      = '0;
        ml_sum        = '0;
        do_lit_done   = 1'b0;
        do_match_done = 1'b0;
        emit_lit      = 1'b0;
        emit_seq      = 1'b0;
        emit_fin      = 1'b0;
        clear_all     = 1'b0;
        fail_code     = lz4bs_pkg::ERR_NONE;
        seq_ll        = '0;
        seq_ml        = '0;
        seq_off       = '0;
        fin_seq       = '0;
        fin_lit       = '0;

        if (fire && drain_reg)
        begin
            // dropping bytes after an error until the block ends
            clear_all = last;
        end
        else if (fire)
        begin
            unique case (phase_reg)
                lz4bs_pkg::PH_LIT_EXT:
                begin
                    lit_sum = {1'b0, lit_acc_reg} + (lz4bs_pkg::LEN_W+1)'(b);
                    if (lit_sum > (lz4bs_pkg::LEN_W+1)'(lz4bs_pkg::PAGE_BYTES + 1))
                        lit_acc_next = lz4bs_pkg::LEN_W'(lz4bs_pkg::PAGE_BYTES + 1);
                    else
                        lit_acc_next = lit_sum[lz4bs_pkg::LEN_W-1:0];
                    if (b != lz4bs_pkg::EXT_CONTINUE)
                        do_lit_done = 1'b1;
                    else if (last)
                        fail_code = lz4bs_pkg::ERR_TRUNCATED;
                end
                lz4bs_pkg::PH_LITERALS:
                begin
                    emit_lit = 1'b1;
                    lit_cnt_next = lit_cnt_reg + 1'b1;
                    if (lit_rem_reg != '0)
                        lit_rem_next = lit_rem_reg - 1'b1;
                    if (lit_rem_next == '0)
                    begin
                        if (last)
                            emit_seq = 1'b1;
                        else
                            phase_next = lz4bs_pkg::PH_OFF_LO;
                    end
                    else if (last)
                        fail_code = lz4bs_pkg::ERR_TRUNCATED;
                end
                lz4bs_pkg::PH_OFF_LO:
                begin
                    off_lo_next = b;
                    if (last)
                        fail_code = lz4bs_pkg::ERR_TRUNCATED;
                    else
                        phase_next = lz4bs_pkg::PH_OFF_HI;
                end
                lz4bs_pkg::PH_OFF_HI:
                begin
                    offset_next = {b, off_lo_reg};
                    ml_acc_next = lz4bs_pkg::MACC_W'(nibble_reg)
                                + lz4bs_pkg::MACC_W'(lz4bs_pkg::MIN_MATCH);
                    if (nibble_reg == lz4bs_pkg::NIBBLE_EXT)
                    begin
                        if (last)
                            fail_code = lz4bs_pkg::ERR_TRUNCATED;
                        else
                            phase_next = lz4bs_pkg::PH_MATCH_EXT;
                    end
                    else
                        do_match_done = 1'b1;
                end
                lz4bs_pkg::PH_MATCH_EXT:
                begin
                    ml_sum = {1'b0, ml_acc_reg} + (lz4bs_pkg::MACC_W+1)'(b);
                    if (ml_sum > (lz4bs_pkg::MACC_W+1)'(lz4bs_pkg::MATCH_SAT))
                        ml_acc_next = lz4bs_pkg::MACC_W'(lz4bs_pkg::MATCH_SAT);
                    else
                        ml_acc_next = ml_sum[lz4bs_pkg::MACC_W-1:0];
                    if (b != lz4bs_pkg::EXT_CONTINUE)
                        do_match_done = 1'b1;
                    else if (last)
                        fail_code = lz4bs_pkg::ERR_TRUNCATED;
                end
                default:
                begin
                    // token byte
                    nibble_next  = b[3:0];
                    lit_acc_next = lz4bs_pkg::LEN_W'(b[7:4]);
                    ml_acc_next  = '0;
                    offset_next  = '0;
                    off_lo_next  = '0;
                    if (b[7:4] == lz4bs_pkg::NIBBLE_EXT)
                    begin
                        if (last)
                            fail_code = lz4bs_pkg::ERR_TRUNCATED;
                        else
                            phase_next = lz4bs_pkg::PH_LIT_EXT;
                    end
                    else
                        do_lit_done = 1'b1;
                end
            endcase

            // literal length complete: overflow, sequence limit, then truncation, else pick the next phase
            if (do_lit_done)
            begin
                page_sum = {1'b0, lit_cnt_next} + {1'b0, lit_acc_next};
                if (page_sum > (lz4bs_pkg::LEN_W+1)'(lz4bs_pkg::PAGE_BYTES))
                    fail_code = lz4bs_pkg::ERR_LIT_OVER;
                else if (seq_cnt_reg >= lz4bs_pkg::SEQ_W'(lz4bs_pkg::MAX_SEQUENCES))
                    fail_code = lz4bs_pkg::ERR_SEQ_OVER;
                else if (lit_acc_next == '0)
                begin
                    if (last)
                        emit_seq = 1'b1;
                    else
                        phase_next = lz4bs_pkg::PH_OFF_LO;
                end
                else if (last)
                    fail_code = lz4bs_pkg::ERR_TRUNCATED;
                else
                begin
                    lit_rem_next = lit_acc_next;
                    phase_next   = lz4bs_pkg::PH_LITERALS;
                end
            end

            if (do_match_done)
            begin
                if (ml_acc_next > lz4bs_pkg::MACC_W'(lz4bs_pkg::MATCH_MAX))
                    fail_code = lz4bs_pkg::ERR_MATCH_LEN;
                else
                    emit_seq = 1'b1;
            end

            if (emit_seq)
            begin
                seq_ll       = lit_acc_next;
                seq_ml       = ml_acc_next[15:0];
                seq_off      = offset_next;
                seq_cnt_next = seq_cnt_reg + 1'b1;
                phase_next   = lz4bs_pkg::PH_TOKEN;
                if (last)
                begin
                    emit_fin  = 1'b1;
                    fin_seq   = seq_cnt_next;
                    fin_lit   = lit_cnt_next;
                    clear_all = 1'b1;
                end
            end

            if (fail_code != lz4bs_pkg::ERR_NONE)
            begin
                if (last)
                    clear_all = 1'b1;
                else
                    drain_next = 1'b1;
            end
        end

        if (clear_all)
        begin
            phase_next   = lz4bs_pkg::PH_TOKEN;
            nibble_next  = '0;
            lit_acc_next = '0;
            lit_rem_next = '0;
            off_lo_next  = '0;
            offset_next  = '0;
            ml_acc_next  = '0;
            lit_cnt_next = '0;
            seq_cnt_next = '0;
            drain_next   = 1'b0;
        end
    end

    // records of this byte, packed in order
    always_comb
    begin
        k      = 2'd0;
        bundle = '0;
        if (emit_lit)
        begin
            bundle.recs[k] = lz4bs_pkg::rec_literal(b);
            k = k + 2'd1;
        end
        if (emit_seq)
        begin
            bundle.recs[k] = lz4bs_pkg::rec_sequence(seq_ll, seq_ml, seq_off);
            k = k + 2'd1;
        end
        if (emit_fin)
        begin
            bundle.recs[k] = lz4bs_pkg::rec_finished(fin_seq, fin_lit);
            k = k + 2'd1;
        end
        if (fail_code != lz4bs_pkg::ERR_NONE)
        begin
            bundle.recs[k] = lz4bs_pkg::rec_error(fail_code);
            k = k + 2'd1;
        end
        bundle.count = k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lz4bs_pkg::PH_TOKEN;
            nibble_reg  <= '0;
            lit_acc_reg <= '0;
            lit_rem_reg <= '0;
            off_lo_reg  <= '0;
            offset_reg  <= '0;
            ml_acc_reg  <= '0;
            lit_cnt_reg <= '0;
            seq_cnt_reg <= '0;
            drain_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            nibble_reg  <= nibble_next;
            lit_acc_reg <= lit_acc_next;
            lit_rem_reg <= lit_rem_next;
            off_lo_reg  <= off_lo_next;
            offset_reg  <= offset_next;
            ml_acc_reg  <= ml_acc_next;
            lit_cnt_reg <= lit_cnt_next;
            seq_cnt_reg <= seq_cnt_next;
            drain_reg   <= drain_next;
        end
    end

endmodule

// ===== design/lz4bs_out_buf.sv =====
`include "assert_macros.svh"

module lz4bs_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_fire,
    input  lz4bs_pkg::bundle_t  bundle,
    output logic                can_load,
    output logic                result_valid,
    input  logic                result_ready,
    output lz4bs_pkg::out_t     result
);

    lz4bs_pkg::bundle_t  buf_reg, buf_next;
    logic [1:0]          idx_reg, idx_next;
    logic                vld_reg, vld_next;
    logic                take;
    logic                at_last;
    logic                load;

    assign at_last  = (idx_reg == buf_reg.count - 2'd1);
    assign take     = vld_reg && result_ready;
    assign can_load = !vld_reg || (take && at_last);
    assign load     = item_fire && (bundle.count != 2'd0);

    always_comb
    begin
        buf_next = buf_reg;
        idx_next = idx_reg;
        vld_next = vld_reg;
        if (load)
        begin
            buf_next = bundle;
            idx_next = 2'd0;
            vld_next = 1'b1;
        end
        else if (take)
        begin
            if (at_last)
                vld_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_comb
    begin
        result             = buf_reg.recs[idx_reg];
        result.last_of_run = at_last;
    end

    assign result_valid = vld_reg;

    `CHECK_CLK(a_idx_in_range, clk, rst_n, vld_reg |-> (idx_reg < buf_reg.count))
    `CHECK_CLK(a_load_starts, clk, rst_n, load |=> (vld_reg && idx_reg == 2'd0))
    `CHECK_CLK(a_step_next, clk, rst_n,
        (take && !at_last) |=> (vld_reg && idx_reg == $past(idx_reg) + 2'd1))
    `CHECK_ALWAYS(a_load_only_when_free, clk, !(rst_n && load && !can_load))

endmodule

// ===== design/lz4_block_sequence_splitter.sv =====
// lz4 block splitter: takes a compressed block one byte per request (end_of_block on
// the final byte) and returns literal bytes, one sequence record per sequence
// (literal length, 16-bit offset, match length with the minimum of 4 included),
// a finished record with the totals, or an error record; after an error the
// bytes up to end_of_block are dropped. each input byte is parsed in the cycle
// it is accepted, so a new byte is taken every clock as long as each byte gives
// at most one result and the result side keeps up; a byte that gives two or
// three results (a literal closing the block, a sequence closing the block)
// holds the input while the result register hands them out. bytes that give
// no result do not hold the input themselves, but like any byte they wait
// while earlier results are still pending.
module lz4_block_sequence_splitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  lz4bs_pkg::in_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output lz4bs_pkg::out_t  result
);

    // all results of one byte, straight from the parser
    lz4bs_pkg::bundle_t  bundle;
    logic                item_fire;
    logic                can_load;

    assign item_ready = can_load;
    assign item_fire  = item_valid && can_load;

    // token, extension, literal and offset tracking plus block counters
    lz4bs_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (item_fire),
        .item   (item),
        .bundle (bundle)
    );

    // result register: hands out the bundle one record at a time
    lz4bs_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_fire    (item_fire),
        .bundle       (bundle),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
